[design/emd_pkg.sv]
// ----------------------------------------------------------------------------
// emd_pkg
// Shared types and constants of the ensemble mean and deviation core: stream
// field layout, register indexes, controller states, command and status.
// ----------------------------------------------------------------------------
package emd_pkg;

   // Field widths fixed by the interface
   localparam int SAMPLE_W    = 24;
   localparam int TIME_W      = 32;
   localparam int IDX_W       = 10;
   localparam int STAT_W      = 24;

   // Request tdata: sample, time_value
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TIME_LSB = SAMPLE_W;

   // Response tdata: point_index, time_out, mean_value, sigma_value, zero pad
   localparam int RSP_TDATA_W   = 96;
   localparam int RSP_TIME_LSB  = IDX_W;
   localparam int RSP_MEAN_LSB  = RSP_TIME_LSB + TIME_W;
   localparam int RSP_SIGMA_LSB = RSP_MEAN_LSB + STAT_W;

   // Configuration port
   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 11;
   localparam int CFG_RUNS_W    = 7;
   localparam int CFG_POINTS_W  = 11;
   localparam int RUN_CNT_W     = 7;
   localparam logic [CSR_ADDR_W-1:0] REG_NUM_RUNS       = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_POINTS_PER_RUN = 1'b1;
   localparam logic [CFG_RUNS_W-1:0]   NUM_RUNS_RESET       = 7'd2;
   localparam logic [CFG_POINTS_W-1:0] POINTS_PER_RUN_RESET = 11'd1024;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_UPDATE,
      ST_MULT,
      ST_MERGE,
      ST_DIFF,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_EMIT
   } emd_state_type;

   typedef struct packed {
      logic accept;
      logic square;
      logic update;
      logic mult;
      logic merge;
      logic diff;
      logic div_start;
      logic root_start;
      logic emit;
   } emd_cmd_type;

   typedef struct packed {
      logic active;
      logic last_item;
      logic div_busy;
      logic root_busy;
      logic out_free;
   } emd_status_type;

endpackage

[design/emd_ram.sv]
// ----------------------------------------------------------------------------
// emd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module emd_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/emd_div.sv]
// ----------------------------------------------------------------------------
// emd_div
// Serial restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module emd_div #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR_W  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEPS = 4;
   localparam int PAD_W = ((DIVIDEND_W + STEPS - 1) / STEPS) * STEPS;
   localparam int ITER  = PAD_W / STEPS;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [PAD_W-1:0]     shift_ff, shift_in;
   logic [DIVISOR_W:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff;
   logic [CNT_W-1:0]     cnt_ff;

   always_comb begin
      logic [PAD_W-1:0]   shift_v;
      logic [DIVISOR_W:0] rem_v;
      shift_v = shift_ff;
      rem_v   = rem_ff;
      for (int i = 0; i < STEPS; i++) begin
         rem_v   = {rem_v[DIVISOR_W-1:0], shift_v[PAD_W-1]};
         shift_v = {shift_v[PAD_W-2:0], 1'b0};
         if (rem_v >= {1'b0, div_ff}) begin
            rem_v      = rem_v - {1'b0, div_ff};
            shift_v[0] = 1'b1;
         end
      end
      shift_in = shift_v;
      rem_in   = rem_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(ITER);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= PAD_W'(dividend);
         rem_ff   <= '0;
         div_ff   <= divisor;
      end else if (cnt_ff != '0) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = shift_ff[DIVIDEND_W-1:0];

endmodule

[design/emd_sqrt.sv]
// ----------------------------------------------------------------------------
// emd_sqrt
// Serial integer square root (floor), two root bits per cycle.
// ----------------------------------------------------------------------------
module emd_sqrt #(
   parameter int RAD_W = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [RAD_W-1:0]       radicand,
   output logic                   busy,
   output logic [(RAD_W+1)/2-1:0] root
);

   localparam int STEPS = 2;
   localparam int PAD_W = ((RAD_W + 3) / 4) * 4;
   localparam int RW    = PAD_W / 2;
   localparam int ITER  = RW / STEPS;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [PAD_W-1:0] rad_ff, rad_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [RW+1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff;

   always_comb begin
      logic [PAD_W-1:0] rad_v;
      logic [RW-1:0]    root_v;
      logic [RW+1:0]    rem_v;
      logic [RW+1:0]    trial_v;
      rad_v  = rad_ff;
      root_v = root_ff;
      rem_v  = rem_ff;
      for (int i = 0; i < STEPS; i++) begin
         rem_v   = {rem_v[RW-1:0], rad_v[PAD_W-1:PAD_W-2]};
         rad_v   = {rad_v[PAD_W-3:0], 2'b00};
         trial_v = {root_v, 2'b01};
         if (rem_v >= trial_v) begin
            rem_v  = rem_v - trial_v;
            root_v = {root_v[RW-2:0], 1'b1};
         end else begin
            root_v = {root_v[RW-2:0], 1'b0};
         end
      end
      rad_in  = rad_v;
      root_in = root_v;
      rem_in  = rem_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(ITER);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= PAD_W'(radicand);
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (cnt_ff != '0) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff[(RAD_W+1)/2-1:0];

endmodule

[design/emd_dpath.sv]
// ----------------------------------------------------------------------------
// emd_dpath
// Datapath: configuration, run and point counters, accumulator RAM, products,
// shared serial divide and root units, and the result register.
// ----------------------------------------------------------------------------
module emd_dpath #(
   parameter int MAX_POINTS  = 1024,
   parameter int MAX_RUNS    = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [emd_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [emd_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [emd_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  emd_pkg::emd_cmd_type                  cmd,
   output emd_pkg::emd_status_type               status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [emd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);

   localparam int PTR_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LOG_RUNS = $clog2(MAX_RUNS);
   localparam int NB       = $clog2(MAX_RUNS + 1);
   localparam int SUM_W    = SAMPLE_BITS + LOG_RUNS;
   localparam int SQ_W     = 2 * SAMPLE_BITS + LOG_RUNS;
   localparam int LO_W     = SQ_W / 2;
   localparam int HI_W     = SQ_W - LO_W;
   localparam int NUM_W    = SQ_W + NB;
   localparam int DEN_W    = 2 * NB;
   localparam int ROOT_W   = (NUM_W + 1) / 2;
   localparam int TIME_W   = emd_pkg::TIME_W;
   localparam int IDX_W    = emd_pkg::IDX_W;
   localparam int STAT_W   = emd_pkg::STAT_W;
   localparam int RUNS_W   = emd_pkg::CFG_RUNS_W;
   localparam int PTS_W    = emd_pkg::CFG_POINTS_W;
   localparam int RUN_W    = emd_pkg::RUN_CNT_W;
   localparam int RAM_W    = SUM_W + SQ_W + TIME_W;

   // Configuration and counters
   logic [RUNS_W-1:0] num_runs_ff;
   logic [PTS_W-1:0]  points_ff;
   logic [RUN_W-1:0]  run_ff;
   logic [PTR_W-1:0]  point_ff;
   logic [NB-1:0]     eff_n;
   logic [PTS_W-1:0]  eff_p;
   logic              first_now, last_now, wrap_now, final_now;

   // Item registers
   logic [SAMPLE_BITS-1:0]   x_ff;
   logic [TIME_W-1:0]        time_ff;
   logic [PTR_W-1:0]         idx_ff;
   logic                     first_ff, last_ff, final_ff;
   logic [2*SAMPLE_BITS-1:0] xsq_ff;

   // Accumulation and statistics
   logic [RAM_W-1:0]      rd_data, wr_data;
   logic [SUM_W-1:0]      rd_sum, sum_in, sum_ff;
   logic [SQ_W-1:0]       rd_sq, sq_in, sq_ff;
   logic [TIME_W-1:0]     rd_time, tout_in, tout_ff;
   logic [NB+LO_W-1:0]    pa_lo_ff;
   logic [NB+HI_W-1:0]    pa_hi_ff;
   logic [2*SUM_W-1:0]    pb_ff;
   logic [DEN_W-1:0]      den_ff;
   logic [NUM_W-1:0]      pa_ff;
   logic [NUM_W-1:0]      num_ff;
   logic [SUM_W-1:0]      mean_q;
   logic [NUM_W-1:0]      var_q;
   logic [ROOT_W-1:0]     root;
   logic                  mean_busy, var_busy, root_busy;
   logic                  sigma_ok;

   // Result register
   logic                        rsp_tvalid_ff;
   logic [emd_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                        rsp_tuser_ff, rsp_tlast_ff;

   // Clamp the programmed counts to the supported range
   always_comb begin
      if (num_runs_ff == '0) begin
         eff_n = NB'(1);
      end else if (32'(num_runs_ff) > MAX_RUNS) begin
         eff_n = NB'(MAX_RUNS);
      end else begin
         eff_n = NB'(num_runs_ff);
      end
      if (points_ff == '0) begin
         eff_p = PTS_W'(1);
      end else if (32'(points_ff) > MAX_POINTS) begin
         eff_p = PTS_W'(MAX_POINTS);
      end else begin
         eff_p = points_ff;
      end
   end

   assign status.active = (32'(run_ff) < 32'(eff_n));
   assign first_now     = (run_ff == '0);
   assign last_now      = ((32'(run_ff) + 32'd1) == 32'(eff_n));
   assign wrap_now      = ((32'(point_ff) + 32'd1) >= 32'(eff_p));
   assign final_now     = ((32'(point_ff) + 32'd1) == 32'(eff_p));
   assign sigma_ok      = (32'(eff_n) >= 32'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_runs_ff <= emd_pkg::NUM_RUNS_RESET;
         points_ff   <= emd_pkg::POINTS_PER_RUN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            emd_pkg::REG_NUM_RUNS:       num_runs_ff <= csr_wdata[RUNS_W-1:0];
            emd_pkg::REG_POINTS_PER_RUN: points_ff   <= csr_wdata[PTS_W-1:0];
            default: ;
         endcase
      end
   end

   // Restart collection on any register write
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         run_ff   <= '0;
         point_ff <= '0;
      end else if (cmd.accept && status.active) begin
         if (wrap_now) begin
            point_ff <= '0;
            run_ff   <= run_ff + RUN_W'(1);
         end else begin
            point_ff <= point_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff     <= req_tdata[SAMPLE_BITS-1:0];
         time_ff  <= req_tdata[emd_pkg::REQ_TIME_LSB +: TIME_W];
         idx_ff   <= point_ff;
         first_ff <= first_now;
         last_ff  <= last_now;
         final_ff <= final_now;
      end
      if (cmd.square) begin
         xsq_ff <= (2*SAMPLE_BITS)'(x_ff) * (2*SAMPLE_BITS)'(x_ff);
      end
   end

   assign status.last_item = last_ff;

   emd_ram #(
      .WIDTH  (RAM_W),
      .DEPTH  (MAX_POINTS),
      .ADDR_W (PTR_W)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (point_ff),
      .rd_data (rd_data)
   );

   assign rd_sum  = rd_data[SUM_W-1:0];
   assign rd_sq   = rd_data[SUM_W +: SQ_W];
   assign rd_time = rd_data[SUM_W + SQ_W +: TIME_W];

   // First run overwrites the entry; later runs accumulate
   always_comb begin
      if (first_ff) begin
         sum_in  = SUM_W'(x_ff);
         sq_in   = SQ_W'(xsq_ff);
         tout_in = time_ff;
      end else begin
         sum_in  = rd_sum + SUM_W'(x_ff);
         sq_in   = rd_sq + SQ_W'(xsq_ff);
         tout_in = rd_time;
      end
   end

   assign wr_data = {tout_in, sq_in, sum_in};

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         tout_ff <= tout_in;
      end
      if (cmd.mult) begin
         pa_lo_ff <= (NB+LO_W)'(eff_n) * (NB+LO_W)'(sq_ff[LO_W-1:0]);
         pa_hi_ff <= (NB+HI_W)'(eff_n) * (NB+HI_W)'(sq_ff[SQ_W-1:LO_W]);
         pb_ff    <= (2*SUM_W)'(sum_ff) * (2*SUM_W)'(sum_ff);
         den_ff   <= DEN_W'(eff_n) * DEN_W'(eff_n - NB'(1));
      end
      if (cmd.merge) begin
         pa_ff <= (NUM_W'(pa_hi_ff) << LO_W) + NUM_W'(pa_lo_ff);
      end
      if (cmd.diff) begin
         num_ff <= (pa_ff > NUM_W'(pb_ff)) ? (pa_ff - NUM_W'(pb_ff)) : '0;
      end
   end

   emd_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (NB)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (eff_n),
      .busy     (mean_busy),
      .quotient (mean_q)
   );

   emd_div #(
      .DIVIDEND_W (NUM_W),
      .DIVISOR_W  (DEN_W)
   ) u_var_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_ff),
      .divisor  (den_ff),
      .busy     (var_busy),
      .quotient (var_q)
   );

   emd_sqrt #(
      .RAD_W (NUM_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (var_q),
      .busy     (root_busy),
      .root     (root)
   );

   assign status.div_busy  = mean_busy || var_busy;
   assign status.root_busy = root_busy;

   always_comb begin
      rsp_tdata_in = '0;
      rsp_tdata_in[IDX_W-1:0]                          = IDX_W'(idx_ff);
      rsp_tdata_in[emd_pkg::RSP_TIME_LSB +: TIME_W]    = tout_ff;
      rsp_tdata_in[emd_pkg::RSP_MEAN_LSB +: STAT_W]    = STAT_W'(mean_q);
      rsp_tdata_in[emd_pkg::RSP_SIGMA_LSB +: STAT_W]   = sigma_ok ? STAT_W'(root) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= sigma_ok;
         rsp_tlast_ff <= final_ff;
      end
   end

   assign status.out_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_tvalid_ff;
   assign rsp_tdata       = rsp_tdata_ff;
   assign rsp_tuser       = rsp_tuser_ff;
   assign rsp_tlast       = rsp_tlast_ff;

endmodule

[design/emd_ctrl.sv]
// ----------------------------------------------------------------------------
// emd_ctrl
// Controller: sequences accumulate, product, divide, root and result load.
// ----------------------------------------------------------------------------
module emd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  emd_pkg::emd_status_type status,
   output emd_pkg::emd_cmd_type    cmd
);

   emd_pkg::emd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= emd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         emd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            // drop items past the end of the collection
            if (req_tvalid && status.active) begin
               state_in = emd_pkg::ST_SQUARE;
            end
         end
         emd_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = emd_pkg::ST_UPDATE;
         end
         emd_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.last_item ? emd_pkg::ST_MULT : emd_pkg::ST_IDLE;
         end
         emd_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = emd_pkg::ST_MERGE;
         end
         emd_pkg::ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = emd_pkg::ST_DIFF;
         end
         emd_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = emd_pkg::ST_DIV_GO;
         end
         emd_pkg::ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = emd_pkg::ST_DIV_WAIT;
         end
         emd_pkg::ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               state_in = emd_pkg::ST_ROOT_GO;
            end
         end
         emd_pkg::ST_ROOT_GO: begin
            cmd.root_start = 1'b1;
            state_in       = emd_pkg::ST_ROOT_WAIT;
         end
         emd_pkg::ST_ROOT_WAIT: begin
            if (!status.root_busy) begin
               state_in = emd_pkg::ST_EMIT;
            end
         end
         emd_pkg::ST_EMIT: begin
            // hold until the result register can take the item
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = emd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = emd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[design/ensemble_mean_and_deviation_core.sv]
// ----------------------------------------------------------------------------
// ensemble_mean_and_deviation_core
// Per-point ensemble mean and sample standard deviation over repeated runs.
//
// Samples (unsigned Q12.12) arrive run-major: every point of run 0, then of
// run 1, and so on. Each point keeps an exact sum, sum of squares and the run
// 0 time stamp in one accumulator RAM. On the last run's sample for a point
// the core returns the point index, the stored time, the truncated mean
// sum/N and sigma = isqrt((N*sumsq - sum^2) / (N*(N-1))); with one run sigma
// is 0 and tuser (sigma valid) is low, and tlast marks the last point.
// Samples beyond points_per_run * num_runs are taken and dropped; a write to
// either register restarts the collection. An item of an earlier run passes
// through RAM read, square and accumulate write-back. An item of the last
// run then goes on to form the products and start the dividers, the
// variance divide (16 steps of 4 quotient bits for a 61-bit dividend at the
// default sizes; the mean divide runs in parallel), the square root (16
// steps of 2 root bits) and the result load, and takes longer while an
// earlier result still waits to be taken. No new item is taken before the
// last one is through. A finished result waits in the output register
// while the next item is taken. The accumulator RAM needs no clearing
// after reset: run 0 writes every entry before the read data of that entry
// is used.
// ----------------------------------------------------------------------------
module ensemble_mean_and_deviation_core #(
   parameter int MAX_POINTS  = 1024,
   parameter int MAX_RUNS    = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration: index 0 num_runs, index 1 points_per_run
   input  logic                             csr_we,
   input  logic [emd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [emd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // request: [23:0] sample, [55:24] time_value
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [emd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response: [9:0] point_index, [41:10] time_out, [65:42] mean_value,
   //           [89:66] sigma_value, [95:90] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [emd_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // response tuser: [0] sigma_valid; tlast: final_point
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   emd_pkg::emd_cmd_type    cmd;
   emd_pkg::emd_status_type status;

   // Sequence the accumulate and statistics steps
   emd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold counters, accumulators, arithmetic units and the result register
   emd_dpath #(
      .MAX_POINTS  (MAX_POINTS),
      .MAX_RUNS    (MAX_RUNS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // A divide start must leave the dividers running
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider not busy after start");

   // Never load a result over one that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result overwritten before taken");

   // No item is taken while the arithmetic units work
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (status.div_busy || status.root_busy) |-> !req_tready)
      else $error("item accepted while units busy");

   // The root starts only on a settled quotient
   a_root_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.root_start |-> !status.div_busy)
      else $error("root started before divide finished");
`endif

endmodule

[tb/ensemble_mean_and_deviation_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ensemble_mean_and_deviation_core_tb
// Self-checking bench for the ensemble mean and deviation core. Streams
// run-major sample collections under many run and point counts, predicts
// every point's time, mean and sample deviation in exact integers, and
// compares each returned item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ensemble_mean_and_deviation_core_tb;
   import emd_pkg::*;

   localparam int N_POINTS       = 1024;
   localparam int N_RUNS         = 64;
   localparam int N_SAMPLE_BITS  = 24;
   // Cycles to let an in-flight item finish once nothing is expected
   localparam int SETTLE_CYCLES  = 100;
   // Longest wait for outstanding results before they are declared lost
   localparam int DRAIN_LIMIT    = 5000;
   localparam int REPORT_LIMIT   = 100;
   localparam int RANDOM_ITEMS   = 760;
   // Items sent under a point count above the limit
   localparam int CLAMP_ITEMS    = 40;

   // How the samples of one point are chosen during a collection
   typedef enum int {
      MIX_WIDE,
      MIX_RAILS,
      MIX_NEAR,
      MIX_FLAT
   } sample_mix_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      logic [IDX_W-1:0]  point;
      logic [TIME_W-1:0] stamp;
      logic [STAT_W-1:0] mean;
      logic [STAT_W-1:0] sigma;
      logic              sigma_ok;
      logic              last_point;
   } point_stat_type;

   // -------------------------------------------------------------------------
   // Per-point ensemble statistics predictor and result store
   // -------------------------------------------------------------------------
   class point_stats_predictor;
      logic [CFG_RUNS_W-1:0]   runs_reg;
      logic [CFG_POINTS_W-1:0] points_reg;
      int unsigned             run_no;
      int unsigned             point_no;
      longint unsigned         sums    [N_POINTS];
      longint unsigned         squares [N_POINTS];
      logic [TIME_W-1:0]       stamps  [N_POINTS];
      point_stat_type          due_stats [$];
      int unsigned             failures;

      function new();
         runs_reg   = NUM_RUNS_RESET;
         points_reg = POINTS_PER_RUN_RESET;
         run_no     = 0;
         point_no   = 0;
         failures   = 0;
      endfunction

      function int unsigned eff_runs();
         if (runs_reg == 0) return 1;
         if (runs_reg > N_RUNS) return N_RUNS;
         return 32'(runs_reg);
      endfunction

      function int unsigned eff_points();
         if (points_reg == 0) return 1;
         if (points_reg > N_POINTS) return N_POINTS;
         return 32'(points_reg);
      endfunction

      // Any register write restarts the collection
      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
         if (addr == REG_NUM_RUNS) begin
            runs_reg = value[CFG_RUNS_W-1:0];
         end else if (addr == REG_POINTS_PER_RUN) begin
            points_reg = value[CFG_POINTS_W-1:0];
         end
         run_no   = 0;
         point_no = 0;
      endfunction

      // Largest r with r*r <= v, built one bit at a time from the top
      function longint unsigned floor_root(longint unsigned v);
         longint unsigned r;
         longint unsigned trial;
         int              b;
         r = 0;
         for (b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v) r = trial;
         end
         return r;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw, logic [TIME_W-1:0] stamp);
         int unsigned     n;
         int unsigned     p;
         int unsigned     k;
         longint unsigned x;
         longint unsigned spread;
         point_stat_type  r;
         n = eff_runs();
         p = eff_points();
         k = point_no;
         // past the end of the collection: the item is dropped
         if (run_no >= n) return;
         x = 64'(raw) & ((64'd1 << N_SAMPLE_BITS) - 64'd1);
         if (run_no == 0) begin
            sums[k]    = x;
            squares[k] = x * x;
            stamps[k]  = stamp;
         end else begin
            sums[k]    += x;
            squares[k] += x * x;
         end
         if (run_no == n - 1) begin
            r.point      = k[IDX_W-1:0];
            r.stamp      = stamps[k];
            r.mean       = STAT_W'(sums[k] / n);
            r.sigma      = '0;
            r.sigma_ok   = 1'b0;
            if (n >= 2) begin
               spread = (n * squares[k] > sums[k] * sums[k]) ?
                        n * squares[k] - sums[k] * sums[k] : 64'd0;
               r.sigma    = STAT_W'(floor_root(spread / (n * (n - 1))));
               r.sigma_ok = 1'b1;
            end
            r.last_point = (k == p - 1);
            due_stats.push_back(r);
         end
         if (k + 1 >= p) begin
            point_no = 0;
            run_no++;
         end else begin
            point_no = k + 1;
         end
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         failures++;
         if (failures <= REPORT_LIMIT) $error("%s expected 0x%0h got 0x%0h", what, want, got);
      endfunction

      function void check_point(logic [RSP_TDATA_W-1:0] data, logic user, logic last);
         point_stat_type r;
         if (due_stats.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $error("unexpected result for point_index 0x%0h", data[IDX_W-1:0]);
            return;
         end
         r = due_stats.pop_front();
         if (data[IDX_W-1:0] !== r.point)
            flag("point_index", 64'(r.point), 64'(data[IDX_W-1:0]));
         if (data[RSP_TIME_LSB +: TIME_W] !== r.stamp)
            flag("time_out", 64'(r.stamp), 64'(data[RSP_TIME_LSB +: TIME_W]));
         if (data[RSP_MEAN_LSB +: STAT_W] !== r.mean)
            flag("mean_value", 64'(r.mean), 64'(data[RSP_MEAN_LSB +: STAT_W]));
         if (data[RSP_SIGMA_LSB +: STAT_W] !== r.sigma)
            flag("sigma_value", 64'(r.sigma), 64'(data[RSP_SIGMA_LSB +: STAT_W]));
         if (user !== r.sigma_ok)
            flag("sigma_valid", 64'(r.sigma_ok), 64'(user));
         if (last !== r.last_point)
            flag("final_point", 64'(r.last_point), 64'(last));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // [23:0] sample, [55:24] time_value
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // [9:0] point_index, [41:10] time_out, [65:42] mean_value,
   // [89:66] sigma_value, [95:90] zero
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   // [0] sigma_valid
   logic                    rsp_tuser;
   logic                    rsp_tlast;

   ensemble_mean_and_deviation_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   point_stats_predictor sb = new();

   // Percent of cycles the sender idles and the receiver stalls
   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;

   sample_mix_type      pt_mix  [N_POINTS];
   logic [SAMPLE_W-1:0] pt_base [N_POINTS];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: check every handshake seen at this edge, then pick the
   // ready level for the next cycle. Values read here are the pre-edge ones.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_point(rsp_tdata, rsp_tuser, rsp_tlast);
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            gap_pct = 0;  stall_pct = 0;
         end
         IDLE_SENDER: begin
            gap_pct = 56; stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            gap_pct = 0;  stall_pct = 56;
         end
         default: begin
            gap_pct = 18; stall_pct = 18;
         end
      endcase
   endtask

   // Hold the write strobe high; the caller drops it after the last write
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_addr  <= addr;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      sb.write_reg(addr, value);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] runs,
                            input logic [CSR_DATA_W-1:0] points);
      write_csr(REG_NUM_RUNS, runs);
      write_csr(REG_POINTS_PER_RUN, points);
      csr_we <= 1'b0;
   endtask

   // Offer one item; valid stays high across back-to-back items
   task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] stamp);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < gap_pct) @(posedge clock);
      end
      req_tdata  <= {stamp, smp};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(smp, stamp);
   endtask

   // Drop valid, wait for every expected result, then let the core go idle.
   // Results that never show up are reported here so the run can go on.
   task automatic settle_block();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.due_stats.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.due_stats.size() != 0) begin
         sb.failures += sb.due_stats.size();
         $error("%0d results never arrived", sb.due_stats.size());
         sb.due_stats.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic plan_points(input int unsigned p);
      int unsigned k;
      for (k = 0; k < p; k++) begin
         pt_mix[k]  = sample_mix_type'($urandom_range(MIX_WIDE, MIX_FLAT));
         pt_base[k] = SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
      end
   endtask

   function automatic logic [SAMPLE_W-1:0] draw_sample(input int unsigned k);
      case (pt_mix[k])
         MIX_WIDE:  return SAMPLE_W'($urandom_range(0, 24'hFFFFFF));
         MIX_RAILS: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
         MIX_NEAR:  return pt_base[k] + SAMPLE_W'($urandom_range(0, 15));
         default:   return pt_base[k];
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] draw_stamp();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return $urandom;
   endfunction

   // Stream the first 'count' items of a run-major collection of p points
   task automatic send_collection(input int unsigned count, input int unsigned p);
      int unsigned i;
      for (i = 0; i < count; i++) send_item(draw_sample(i % p), draw_stamp());
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int unsigned counted;
      int unsigned phase;
      int unsigned n;
      int unsigned p;
      int unsigned max_p;
      int unsigned total;
      int unsigned cut;
      int unsigned r;
      logic [CSR_DATA_W-1:0] runs_val;
      logic [CSR_DATA_W-1:0] points_val;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- Directed: two runs, three points, rails on the samples --------
      set_idling(IDLE_NONE);
      configure(CSR_DATA_W'(2), CSR_DATA_W'(3));
      send_item(24'h000000, 32'hFFFFFFFF);
      send_item(24'hFFFFFF, 32'h00000000);
      send_item(24'h000000, 32'h5A5AA5A5);
      // run 1 times must not replace the run 0 stamps
      send_item(24'hFFFFFF, 32'h12345678);
      send_item(24'hFFFFFF, 32'hFFFFFFFF);
      send_item(24'h000000, 32'h00000000);
      settle_block();

      // --- Directed: zero counts act as one run of one point; extra items
      // past the end are dropped without a result
      configure(CSR_DATA_W'(0), CSR_DATA_W'(0));
      send_item(24'hABCDEF, 32'hDEADBEEF);
      send_item(24'hFFFFFF, 32'hFFFFFFFF);
      send_item(24'h000001, 32'h00000001);
      settle_block();

      // --- Directed: a register write in the middle restarts collection ---
      configure(CSR_DATA_W'(3), CSR_DATA_W'(2));
      plan_points(2);
      send_collection(3, 2);
      settle_block();
      write_csr(REG_POINTS_PER_RUN, CSR_DATA_W'(2));
      csr_we <= 1'b0;
      send_collection(6, 2);
      settle_block();

      // --- Run count above the limit clamps to 64: one point pinned at
      // full scale, one swinging between rails
      set_idling(IDLE_BOTH);
      configure(CSR_DATA_W'(127), CSR_DATA_W'(2));
      pt_mix[0]  = MIX_FLAT;
      pt_base[0] = 24'hFFFFFF;
      pt_mix[1]  = MIX_RAILS;
      send_collection(128, 2);
      settle_block();

      // --- Point count above the limit acts as 1024: a short single-run
      // stretch, every item answered at once
      set_idling(IDLE_SENDER);
      configure(CSR_DATA_W'(1), CSR_DATA_W'(2047));
      plan_points(N_POINTS);
      send_collection(CLAMP_ITEMS, N_POINTS);
      settle_block();

      // --- Random collections under varied counts and idling ---------------
      counted = 0;
      phase   = 0;
      while (counted < RANDOM_ITEMS) begin
         set_idling(idle_mode_type'(phase % 4));
         r = $urandom_range(0, 99);
         if (r < 55)      runs_val = CSR_DATA_W'($urandom_range(2, 6));
         else if (r < 70) runs_val = CSR_DATA_W'(1);
         else if (r < 80) runs_val = CSR_DATA_W'($urandom_range(7, 20));
         else if (r < 88) runs_val = CSR_DATA_W'($urandom_range(21, 64));
         else if (r < 93) runs_val = CSR_DATA_W'(0);
         // upper bits fall outside the seven-bit register
         else             runs_val = CSR_DATA_W'($urandom_range(65, 2047));
         write_csr(REG_NUM_RUNS, runs_val);
         n = sb.eff_runs();
         max_p = 160 / n;
         if (max_p > 48) max_p = 48;
         if ($urandom_range(0, 99) < 8) points_val = CSR_DATA_W'(0);
         else                           points_val = CSR_DATA_W'($urandom_range(1, max_p));
         write_csr(REG_POINTS_PER_RUN, points_val);
         csr_we <= 1'b0;
         p = sb.eff_points();
         total = n * p;
         plan_points(p);
         // now and then break off a collection part way through
         cut = total;
         if (total > 1 && $urandom_range(0, 5) == 0) cut = $urandom_range(1, total - 1);
         send_collection(cut, p);
         if (cut == total) send_collection($urandom_range(0, 2), p);
         counted += cut;
         settle_block();
         phase++;
      end

      if (sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
design/emd_pkg.sv
design/emd_ram.sv
design/emd_div.sv
design/emd_sqrt.sv
design/emd_dpath.sv
design/emd_ctrl.sv
design/ensemble_mean_and_deviation_core.sv
tb/ensemble_mean_and_deviation_core_tb.sv
